// ----- rtl/ssad_pkg.sv -----
// Shared constants and types for the sweep sync pulse angle decoder.
`timescale 1ns / 1ps

package ssad_pkg;

    // Stream word widths
    localparam int IN_TDATA_W  = 48;   // rise_time[31:0], pulse_width[47:32]
    localparam int OUT_TDATA_W = 128;  // angle_x0, angle_y0, angle_x1, angle_y1

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WIDTH_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_CENTER    = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_LONG_PULSE_MIN  = 16'd3360;
    localparam logic [15:0] RST_LONG_PULSE_MAX  = 16'd25200;
    localparam logic [15:0] RST_SYNC_WIDTH_BASE = 16'd4814;
    localparam logic [19:0] RST_SYNC_GAP_MIN    = 20'd31080;
    localparam logic [19:0] RST_SYNC_GAP_MAX    = 20'd36120;
    localparam logic [19:0] RST_ANGLE_CENTER    = 20'd336000;

    // Sync bits = floor(x / 875) for 16-bit x, as (x * ceil(2^26/875)) >> 26
    localparam int          SYNC_BITS_W  = 7;
    localparam int          SYNC_SHIFT   = 26;
    localparam logic [16:0] SYNC_RECIP   = 17'd76696;
    localparam int          SYNC_SKIP_BIT = 2;
    localparam int          SYNC_AXIS_BIT = 0;

    // Angle scale: round(mag * PI_Q28 / CYCLE_TICKS)
    //   PI_Q28 = PI_INT * CYCLE_TICKS + PI_REM
    localparam int          MAG_W       = 21;   // larger magnitudes always saturate
    localparam logic [19:0] CYCLE_TICKS = 20'd699972;
    localparam logic [18:0] HALF_CYCLE  = 19'd349986;
    localparam logic [10:0] PI_INT      = 11'd1204;
    localparam logic [19:0] PI_REM      = 20'd548569;
    // Slightly low estimate of PI_REM / CYCLE_TICKS in Q0.32
    localparam logic [31:0] REM_RECIP   = 32'd3365971600;

    localparam logic [31:0] ANGLE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ANGLE_MIN = 32'h8000_0000;

    // Pipeline depth, input register through output register
    localparam int NUM_STAGES = 7;

    // Per-word control that rides along the angle pipeline
    typedef struct packed {
        logic       done;   // all four angles set with this pulse
        logic       wr;     // an angle is written
        logic [1:0] slot;   // x0, y0, x1, y1
    } ssad_tag_t;

endpackage

// ----- rtl/sweep_sync_pulse_angle_decoder.sv -----
// Top level of the sweep sync pulse angle decoder: pulse classifier and angle pipeline.
`timescale 1ns / 1ps
//
// Usage
//   s_ channel: one word per light pulse, s_tdata = {pulse_width, rise_time}, both in
//   sensor ticks. m_ channel: one word per accepted pulse carrying the four stored
//   angles (Q3.28 radians, saturated); m_tlast is high when this pulse completed all
//   four angles, after which the set marks start over.
//   Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_index on the
//   clock edge; write only while no pulse is in flight.
// Pipeline
//   Seven register stages: input, classify, center offset, scale multiply, quotient
//   check, rounding correction, output. One word per cycle is sustained while
//   m_tready is high.
// Reset
//   aresetn low clears all pipeline valids, the sync slots, the set marks and the
//   stored angles, and loads the register defaults.
// Stall
//   When m_tready is low the output word holds; empty stages keep filling, so up to
//   seven words are taken before s_tready drops.
module sweep_sync_pulse_angle_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [ssad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssad_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Pulse input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ssad_pkg::IN_TDATA_W-1:0] s_tdata,   // rise_time[31:0], pulse_width[47:32]
    // Angle output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ssad_pkg::OUT_TDATA_W-1:0] m_tdata,  // angle_x0, angle_y0, angle_x1, angle_y1
    output logic                             m_tlast   // frame_done
);

    import ssad_pkg::*;

    // Configuration registers
    logic [15:0] long_pulse_min_reg;
    logic [15:0] long_pulse_max_reg;
    logic [15:0] sync_width_base_reg;
    logic [19:0] sync_gap_min_reg;
    logic [19:0] sync_gap_max_reg;
    logic [19:0] angle_center_reg;

    // Decoder state
    logic        expect_second_reg;
    logic [31:0] sync_a_time_reg;
    logic [15:0] sync_a_width_reg;
    logic [31:0] sync_b_time_reg;
    logic [15:0] sync_b_width_reg;
    logic [3:0]  marks_reg;
    logic [3:0]  marks_next;
    logic [31:0] angle_store_reg [4];

    // Pipeline handshake
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;
    logic                  take0;

    // Stage 0: input register
    logic [31:0] in_time_reg;
    logic [15:0] in_width_reg;

    // Classification
    logic                   is_ignore;
    logic                   is_sync;
    logic                   is_sweep;
    logic [31:0]            centre;
    logic [31:0]            gap;
    logic                   gap_ok;
    logic [SYNC_BITS_W-1:0] bits_a;
    logic [SYNC_BITS_W-1:0] bits_b;
    logic                   found;
    logic [1:0]             slot;
    logic [31:0]            sweep;
    logic                   wr;
    logic [3:0]             marks_or;
    ssad_tag_t              tag0;

    // Stage 1
    ssad_tag_t   p1_tag_reg;
    logic [31:0] p1_sweep_reg;

    // Stage 2
    logic [32:0]      offs;
    logic [32:0]      offs_abs;
    ssad_tag_t        p2_tag_reg;
    logic             p2_neg_reg;
    logic             p2_sat_reg;
    logic [MAG_W-1:0] p2_mag_reg;

    // Stage 3
    logic [40:0]      x_prod;
    logic [52:0]      est_prod;
    ssad_tag_t        p3_tag_reg;
    logic             p3_neg_reg;
    logic             p3_sat_reg;
    logic [MAG_W-1:0] p3_mag_reg;
    logic [41:0]      p3_x_reg;
    logic [MAG_W-1:0] p3_est_reg;

    // Stage 4
    ssad_tag_t        p4_tag_reg;
    logic             p4_neg_reg;
    logic             p4_sat_reg;
    logic [MAG_W-1:0] p4_mag_reg;
    logic [41:0]      p4_x_reg;
    logic [MAG_W-1:0] p4_est_reg;
    logic [40:0]      p4_prod_reg;

    // Stage 5
    logic [41:0]    rem;
    ssad_tag_t      p5_tag_reg;
    logic           p5_neg_reg;
    logic           p5_sat_reg;
    logic [MAG_W:0] p5_q2_reg;
    logic [31:0]    p5_base_reg;

    // Stage 6
    logic [32:0] q_sum;
    logic        q_over;
    logic [31:0] angle;
    logic        done_reg;

    // floor(max(w - base, 0) / 875) by reciprocal multiply
    function automatic logic [SYNC_BITS_W-1:0] sync_bits(input logic [15:0] w,
                                                         input logic [15:0] base);
        logic [15:0] diff;
        logic [32:0] prod;
        diff = (w >= base) ? (w - base) : 16'd0;
        prod = {17'd0, diff} * {16'd0, SYNC_RECIP};
        return prod[SYNC_SHIFT +: SYNC_BITS_W];
    endfunction

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_pulse_min_reg  <= RST_LONG_PULSE_MIN;
            long_pulse_max_reg  <= RST_LONG_PULSE_MAX;
            sync_width_base_reg <= RST_SYNC_WIDTH_BASE;
            sync_gap_min_reg    <= RST_SYNC_GAP_MIN;
            sync_gap_max_reg    <= RST_SYNC_GAP_MAX;
            angle_center_reg    <= RST_ANGLE_CENTER;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LONG_PULSE_MIN:  long_pulse_min_reg  <= cfg_wdata[15:0];
                CFG_LONG_PULSE_MAX:  long_pulse_max_reg  <= cfg_wdata[15:0];
                CFG_SYNC_WIDTH_BASE: sync_width_base_reg <= cfg_wdata[15:0];
                CFG_SYNC_GAP_MIN:    sync_gap_min_reg    <= cfg_wdata;
                CFG_SYNC_GAP_MAX:    sync_gap_max_reg    <= cfg_wdata;
                CFG_ANGLE_CENTER:    angle_center_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Ready chain: a stage takes a word when it is empty or its word moves on
    always_comb begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign take0    = vld_reg[0] && rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 0: input register
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            in_time_reg  <= s_tdata[31:0];
            in_width_reg <= s_tdata[47:32];
        end
    end

    // Classify the pulse and pick the angle slot
    always_comb begin
        is_ignore = in_width_reg >= long_pulse_max_reg;
        is_sync   = !is_ignore && (in_width_reg >= long_pulse_min_reg);
        is_sweep  = !is_ignore && !is_sync;
        centre    = in_time_reg + {17'd0, in_width_reg[15:1]};
        gap       = sync_b_time_reg - sync_a_time_reg;
        gap_ok    = !gap[31] && (gap > {12'd0, sync_gap_min_reg})
                    && (gap < {12'd0, sync_gap_max_reg});
        bits_a    = sync_bits(sync_a_width_reg, sync_width_base_reg);
        bits_b    = sync_bits(sync_b_width_reg, sync_width_base_reg);

        found = 1'b1;
        slot  = {1'b0, bits_a[SYNC_AXIS_BIT]};
        sweep = centre - sync_a_time_reg;
        if (bits_a[SYNC_SKIP_BIT]) begin
            slot  = {1'b1, bits_b[SYNC_AXIS_BIT]};
            sweep = centre - sync_b_time_reg;
            found = !bits_b[SYNC_SKIP_BIT];
        end

        wr       = is_sweep && gap_ok && found;
        marks_or = marks_reg | (wr ? (4'b0001 << slot) : 4'b0000);

        marks_next = marks_reg;
        if (is_sweep) begin
            marks_next = (marks_or == 4'hF) ? 4'h0 : marks_or;
        end

        tag0.done = is_sweep && (marks_or == 4'hF);
        tag0.wr   = wr;
        tag0.slot = slot;
    end

    // Sync slots and set marks, updated as each word leaves stage 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_second_reg <= 1'b0;
            sync_a_time_reg   <= '0;
            sync_a_width_reg  <= '0;
            sync_b_time_reg   <= '0;
            sync_b_width_reg  <= '0;
            marks_reg         <= '0;
        end else if (take0) begin
            marks_reg <= marks_next;
            if (is_sweep) begin
                expect_second_reg <= 1'b0;
            end else if (is_sync) begin
                expect_second_reg <= !expect_second_reg;
                if (!expect_second_reg) begin
                    sync_a_time_reg  <= in_time_reg;
                    sync_a_width_reg <= in_width_reg;
                end else begin
                    sync_b_time_reg  <= in_time_reg;
                    sync_b_width_reg <= in_width_reg;
                end
            end
        end
    end

    // Stage 1: decision register
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            p1_tag_reg   <= tag0;
            p1_sweep_reg <= sweep;
        end
    end

    // Stage 2: signed offset from the center, split into sign and magnitude
    always_comb begin
        offs     = {p1_sweep_reg[31], p1_sweep_reg} - {13'd0, angle_center_reg};
        offs_abs = offs[32] ? (33'd0 - offs) : offs;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            p2_tag_reg <= p1_tag_reg;
            p2_neg_reg <= offs[32];
            p2_sat_reg <= |offs_abs[32:MAG_W];
            p2_mag_reg <= offs_abs[MAG_W-1:0];
        end
    end

    // Stage 3: remainder numerator and quotient estimate
    always_comb begin
        x_prod   = {20'd0, p2_mag_reg} * {21'd0, PI_REM};
        est_prod = {32'd0, p2_mag_reg} * {21'd0, REM_RECIP};
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            p3_tag_reg <= p2_tag_reg;
            p3_neg_reg <= p2_neg_reg;
            p3_sat_reg <= p2_sat_reg;
            p3_mag_reg <= p2_mag_reg;
            p3_x_reg   <= {1'b0, x_prod} + {23'd0, HALF_CYCLE};
            p3_est_reg <= est_prod[52:32];
        end
    end

    // Stage 4: estimate times the cycle period
    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            p4_tag_reg  <= p3_tag_reg;
            p4_neg_reg  <= p3_neg_reg;
            p4_sat_reg  <= p3_sat_reg;
            p4_mag_reg  <= p3_mag_reg;
            p4_x_reg    <= p3_x_reg;
            p4_est_reg  <= p3_est_reg;
            p4_prod_reg <= {20'd0, p3_est_reg} * {21'd0, CYCLE_TICKS};
        end
    end

    // Stage 5: estimate is low by at most one; fix it and form the integer part
    assign rem = p4_x_reg - {1'b0, p4_prod_reg};

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            p5_tag_reg  <= p4_tag_reg;
            p5_neg_reg  <= p4_neg_reg;
            p5_sat_reg  <= p4_sat_reg;
            p5_q2_reg   <= {1'b0, p4_est_reg}
                           + {{MAG_W{1'b0}}, (rem >= {22'd0, CYCLE_TICKS})};
            p5_base_reg <= {11'd0, p4_mag_reg} * {21'd0, PI_INT};
        end
    end

    // Stage 6: sum, saturate, apply sign
    always_comb begin
        q_sum  = {1'b0, p5_base_reg} + {11'd0, p5_q2_reg};
        q_over = p5_sat_reg || q_sum[32] || q_sum[31];
        if (q_over) begin
            angle = p5_neg_reg ? ANGLE_MIN : ANGLE_MAX;
        end else begin
            angle = p5_neg_reg ? (32'd0 - q_sum[31:0]) : q_sum[31:0];
        end
    end

    // Output register: the angle store only changes as a word enters it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                angle_store_reg[i] <= '0;
            end
        end else if (rdy[NUM_STAGES-1] && vld_reg[NUM_STAGES-2] && p5_tag_reg.wr) begin
            angle_store_reg[p5_tag_reg.slot] <= angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NUM_STAGES-1]) begin
            done_reg <= p5_tag_reg.done;
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tlast  = done_reg;
    assign m_tdata  = {angle_store_reg[3], angle_store_reg[2],
                       angle_store_reg[1], angle_store_reg[0]};

    // Marks are cleared the moment the fourth one is set
    a_marks_never_full: assert property (@(posedge aclk) disable iff (!aresetn)
        marks_reg != 4'hF)
        else $error("angle set marks reached all-set");

    // Completion clears the marks
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take0 && tag0.done |=> marks_reg == 4'h0)
        else $error("marks not cleared on frame completion");

    // A sweep re-arms the sync pair
    a_sweep_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        take0 && is_sweep |=> !expect_second_reg)
        else $error("sweep did not re-arm sync A");

    // Stored angles move only with a word entering the output register
    a_store_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rdy[NUM_STAGES-1] && vld_reg[NUM_STAGES-2]) |=> $stable(m_tdata))
        else $error("angle store changed without a new word");

    // An open output never back-pressures the input
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the sweep sync pulse angle decoder.
`timescale 1ns / 1ps

module tb_top;
    import ssad_pkg::*;

    // Decoder constants: sync bit step, pi in Q28, sweep period in ticks
    localparam int unsigned       SYNC_STEP    = 875;
    localparam int unsigned       SWEEP_PERIOD = 699972;
    localparam longint unsigned   PI_Q28_RAD   = 64'd843314857;
    localparam int                CYCLE_LIMIT  = 400000;

    typedef enum int {SLOT_X0, SLOT_Y0, SLOT_X1, SLOT_Y1} angle_slot_e;
    typedef enum int {PULSE_IGNORED, PULSE_SYNC, PULSE_SWEEP} pulse_kind_e;

    typedef struct packed {
        logic [15:0] pulse_min;
        logic [15:0] pulse_max;
        logic [15:0] width_base;
        logic [19:0] gap_min;
        logic [19:0] gap_max;
        logic [19:0] center;
    } decoder_regs_t;

    typedef struct packed {
        logic        frame_done;
        logic [31:0] angle_x0;
        logic [31:0] angle_y0;
        logic [31:0] angle_x1;
        logic [31:0] angle_y1;
    } angle_word_t;

    // DUT ports
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // Decoder copy: registers and state
    decoder_regs_t regs;
    logic          want_sync_b;
    logic [31:0]   a_time, b_time;
    logic [15:0]   a_width, b_width;
    logic [31:0]   angles [4];
    logic [3:0]    set_marks;

    // Expected output words, oldest first
    angle_word_t   pending_words [$];

    // Stimulus control and bookkeeping
    int            tx_idle_pct, rx_idle_pct;
    int            hold_request, hold_left;
    logic [31:0]   stamp;
    int            fail_count, cycle_count;
    int            counted_pulses, sync_count, sweep_count, ignored_count;
    int            angle_writes, frames_done, reg_writes;

    sweep_sync_pulse_angle_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run timed out with %0d words outstanding", pending_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output ready: random idling, plus a long hold when one is requested
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Sync bits from a sync pulse width
    function automatic logic [31:0] sync_bits(logic [15:0] w);
        logic [31:0] excess;
        if (w < regs.width_base) return '0;
        excess = 32'(w) - 32'(regs.width_base);
        return excess / SYNC_STEP;
    endfunction

    // Sweep time to Q3.28 radians, rounded half away from zero, saturated
    function automatic logic [31:0] sweep_to_angle(logic [31:0] sweep);
        longint          offset;
        longint unsigned mag, quot;
        offset = longint'($signed(sweep)) - longint'(regs.center);
        mag = (offset < 0) ? 64'(-offset) : 64'(offset);
        quot = (mag * PI_Q28_RAD + 64'(SWEEP_PERIOD / 2)) / 64'(SWEEP_PERIOD);
        if (offset < 0) return (quot >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - quot[31:0];
        return (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
    endfunction

    // Advance the decoder copy by one pulse and form the word it yields
    function automatic void predict_pulse(input logic [31:0] t, input logic [15:0] w,
                                          output angle_word_t word,
                                          output pulse_kind_e kind);
        logic [31:0] centre, gap, bits_a, bits_b, sweep;
        int          slot;
        logic        done;
        done = 1'b0;
        slot = -1;
        sweep = '0;
        if (w >= regs.pulse_max) begin
            kind = PULSE_IGNORED;
            ignored_count++;
        end else if (w >= regs.pulse_min) begin
            kind = PULSE_SYNC;
            sync_count++;
            if (!want_sync_b) begin
                a_time = t;
                a_width = w;
                want_sync_b = 1'b1;
            end else begin
                b_time = t;
                b_width = w;
                want_sync_b = 1'b0;
            end
        end else begin
            kind = PULSE_SWEEP;
            sweep_count++;
            centre = t + {17'd0, w[15:1]};
            gap = b_time - a_time;
            want_sync_b = 1'b0;
            if (!gap[31] && gap > 32'(regs.gap_min) && gap < 32'(regs.gap_max)) begin
                bits_a = sync_bits(a_width);
                bits_b = sync_bits(b_width);
                if (!bits_a[SYNC_SKIP_BIT]) begin
                    slot = bits_a[SYNC_AXIS_BIT] ? SLOT_Y0 : SLOT_X0;
                    sweep = centre - a_time;
                end else if (!bits_b[SYNC_SKIP_BIT]) begin
                    slot = bits_b[SYNC_AXIS_BIT] ? SLOT_Y1 : SLOT_X1;
                    sweep = centre - b_time;
                end
                if (slot >= 0) begin
                    angles[slot] = sweep_to_angle(sweep);
                    set_marks[slot] = 1'b1;
                    angle_writes++;
                end
            end
            if (set_marks == 4'hF) begin
                set_marks = '0;
                done = 1'b1;
                frames_done++;
            end
        end
        word.frame_done = done;
        word.angle_x0 = angles[SLOT_X0];
        word.angle_y0 = angles[SLOT_Y0];
        word.angle_x1 = angles[SLOT_X1];
        word.angle_y1 = angles[SLOT_Y1];
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s: expected %h, got %h", name, expected, actual);
            fail_count++;
        end
    endfunction

    // Output checker
    always @(posedge aclk) begin : result_check
        angle_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("output word with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                check_field("frame_done", 32'(want.frame_done), 32'(m_tlast));
                check_field("angle_x0", want.angle_x0, m_tdata[31:0]);
                check_field("angle_y0", want.angle_y0, m_tdata[63:32]);
                check_field("angle_x1", want.angle_x1, m_tdata[95:64]);
                check_field("angle_y1", want.angle_y1, m_tdata[127:96]);
            end
        end
    end

    // Offer one pulse word and record its expected output once taken
    task automatic send_pulse(input logic [31:0] t, input logic [15:0] w);
        angle_word_t word;
        pulse_kind_e kind;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, t};
        do @(posedge aclk); while (!s_tready);
        predict_pulse(t, w, word, kind);
        pending_words.push_back(word);
        if (kind != PULSE_IGNORED) counted_pulses++;
    endtask

    // Stop offering and let every expected word drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_words.size() != 0);
    endtask

    // Write all six registers, one per clock
    task automatic load_regs(input decoder_regs_t next);
        logic [CFG_IDX_W-1:0]  index_list [6];
        logic [CFG_DATA_W-1:0] value_list [6];
        index_list = '{CFG_LONG_PULSE_MIN, CFG_LONG_PULSE_MAX, CFG_SYNC_WIDTH_BASE,
                       CFG_SYNC_GAP_MIN, CFG_SYNC_GAP_MAX, CFG_ANGLE_CENTER};
        value_list = '{20'(next.pulse_min), 20'(next.pulse_max), 20'(next.width_base),
                       next.gap_min, next.gap_max, next.center};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= index_list[i];
            cfg_wdata <= value_list[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        regs = next;
        reg_writes += 6;
    endtask

    // Sync width carrying the given bits, kept inside the sync band
    function automatic logic [15:0] sync_width(input int unsigned bits);
        int unsigned w;
        w = regs.width_base + bits * SYNC_STEP + $urandom_range(SYNC_STEP - 1);
        if (w < regs.pulse_min || w >= regs.pulse_max)
            w = $urandom_range(regs.pulse_max - 1, regs.pulse_min);
        return w[15:0];
    endfunction

    // One base station cycle: sync A, sync B, then one or more sweeps
    task automatic send_sweep_cycle();
        logic [31:0] a_t, gap, offset;
        logic [15:0] sweep_w;
        int          choice;
        a_t = stamp;
        choice = $urandom_range(99);
        if (choice < 80 && 32'(regs.gap_max) > 32'(regs.gap_min) + 1)
            gap = $urandom_range(32'(regs.gap_max) - 1, 32'(regs.gap_min) + 1);
        else if (choice < 92)
            gap = $urandom_range(32'(regs.gap_max) + 20000);
        else
            gap = 32'd0 - $urandom_range(40000, 1);     // B before A
        send_pulse(a_t, sync_width($urandom_range(7)));
        send_pulse(a_t + gap, sync_width($urandom_range(7)));
        do begin
            offset = ($urandom_range(99) < 5) ? $urandom : $urandom_range(SWEEP_PERIOD);
            sweep_w = 16'($urandom_range(regs.pulse_min - 1));
            send_pulse(a_t + offset - {17'd0, sweep_w[15:1]}, sweep_w);
        end while ($urandom_range(99) < 15);
        stamp = stamp + SWEEP_PERIOD + $urandom_range(4000);
    endtask

    // Stray pulses: random words, lone syncs and over-long pulses
    task automatic send_noise();
        int choice;
        choice = $urandom_range(3);
        if (choice < 2)
            send_pulse($urandom, 16'($urandom));
        else if (choice == 2)
            send_pulse($urandom, sync_width($urandom_range(7)));
        else
            send_pulse($urandom, 16'($urandom_range(65535, regs.pulse_max)));
    endtask

    // Hand-picked pulses under the reset register values
    task automatic test_directed_pulses();
        logic [31:0] t;
        tx_idle_pct = 37;
        rx_idle_pct = 77;
        // over-long pulses, widest and exactly at the limit
        send_pulse(32'hFFFF_FFFF, 16'hFFFF);
        send_pulse(32'd0, RST_LONG_PULSE_MAX);
        // sweep with both slots empty: zero spacing fails the window
        send_pulse(32'd0, 16'd0);
        // x0: A at the sync threshold, B skipped, sweep near the center
        t = 32'd1000;
        send_pulse(t, RST_LONG_PULSE_MIN);
        send_pulse(t + 33600, 16'(RST_SYNC_WIDTH_BASE + 4 * SYNC_STEP));
        send_pulse(t + 336000 - 50, 16'd101);
        // y0: sweep far after A saturates high
        t = 32'd5_000_000;
        send_pulse(t, 16'(RST_SYNC_WIDTH_BASE + SYNC_STEP));
        send_pulse(t + 33600, RST_SYNC_WIDTH_BASE);
        send_pulse(t + 32'h7FF0_0000, 16'd2);
        // x1: A skipped, sweep half a wrap from B saturates low
        t = 32'd9_000_000;
        send_pulse(t, 16'(RST_SYNC_WIDTH_BASE + 4 * SYNC_STEP));
        send_pulse(t + 33600, 16'(RST_SYNC_WIDTH_BASE + 100));
        send_pulse(t + 33600 + 32'h8000_0000, 16'd0);
        // y1 with a timestamp wrap between A and B; widest sweep completes the frame
        t = 32'hFFFF_F000;
        send_pulse(t, 16'(RST_SYNC_WIDTH_BASE + 5 * SYNC_STEP));
        send_pulse(t + 33600, 16'(RST_SYNC_WIDTH_BASE + 2 * SYNC_STEP - 1));
        send_pulse(t + 33600 + 300000, RST_LONG_PULSE_MIN - 16'd1);
        // both syncs skipped, the widest sync width among them
        t = 32'd20_000_000;
        send_pulse(t, 16'(RST_SYNC_WIDTH_BASE + 7 * SYNC_STEP));
        send_pulse(t + 33600, RST_LONG_PULSE_MAX - 16'd1);
        send_pulse(t + 300000, 16'd500);
        // B ahead of A: negative spacing
        t = 32'd30_000_000;
        send_pulse(t, RST_SYNC_WIDTH_BASE);
        send_pulse(t - 33600, RST_SYNC_WIDTH_BASE);
        send_pulse(t + 300000, 16'd500);
    endtask

    // Register corners: equal pulse limits, empty window, zero sync threshold
    task automatic test_register_extremes();
        wait_idle();
        load_regs('{16'd5000, 16'd5000, 16'd0, 20'd0, 20'hFFFFF, 20'd0});
        send_pulse(32'd40_000_000, 16'd4999);
        send_pulse(32'd40_000_100, 16'd5000);
        send_pulse(32'd40_000_200, 16'hFFFF);
        wait_idle();
        load_regs('{16'd1, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF});
        send_pulse(32'd50_000_000, 16'd1);
        send_pulse(32'd50_033_600, 16'hFFFE);
        send_pulse(32'd50_300_000, 16'd0);
        wait_idle();
        load_regs('{16'd0, 16'd16, 16'd0, 20'd0, 20'hFFFFF, 20'd0});
        send_pulse(32'd60_000_000, 16'd0);
    endtask

    // Mostly well-formed station cycles with some stray pulses mixed in
    task automatic test_random_traffic(input decoder_regs_t setting, input int tx_pct,
                                       input int rx_pct, input int pulse_target);
        int start;
        wait_idle();
        load_regs(setting);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = counted_pulses;
        while (counted_pulses - start < pulse_target) begin
            if ($urandom_range(99) < 85) send_sweep_cycle();
            else send_noise();
        end
    endtask

    // Long output hold with a busy sender, so the pipeline fills and stalls input
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 120;
        repeat (14) send_sweep_cycle();
    endtask

    initial begin
        regs = '{RST_LONG_PULSE_MIN, RST_LONG_PULSE_MAX, RST_SYNC_WIDTH_BASE,
                 RST_SYNC_GAP_MIN, RST_SYNC_GAP_MAX, RST_ANGLE_CENTER};
        want_sync_b = 1'b0;
        a_time = '0;
        b_time = '0;
        a_width = '0;
        b_width = '0;
        angles = '{default: '0};
        set_marks = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 0;
        hold_left = 0;
        fail_count = 0;
        cycle_count = 0;
        counted_pulses = 0;
        sync_count = 0;
        sweep_count = 0;
        ignored_count = 0;
        angle_writes = 0;
        frames_done = 0;
        reg_writes = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_pulses();
        test_register_extremes();
        stamp = 32'hFFF0_0000;
        test_random_traffic('{RST_LONG_PULSE_MIN, RST_LONG_PULSE_MAX, RST_SYNC_WIDTH_BASE,
                              RST_SYNC_GAP_MIN, RST_SYNC_GAP_MAX, RST_ANGLE_CENTER},
                            37, 77, 430);
        test_random_traffic('{16'd1000, 16'd9000, 16'd1000, 20'd20000, 20'd60000, 20'd500000},
                            77, 37, 430);
        test_random_traffic('{16'd3360, 16'hFFFF, 16'd4814, 20'd0, 20'hFFFFF, 20'hFFFFF},
                            0, 0, 430);
        test_output_stall();

        // drain, then watch a little longer for stray words
        wait_idle();
        repeat (NUM_STAGES + 2) @(posedge aclk);

        $display("Run covered %0d sync, %0d sweep and %0d ignored pulses: %0d angle updates, %0d frames.",
                 sync_count, sweep_count, ignored_count, angle_writes, frames_done);
        $display("Register writes: %0d over six settings; idle mixes and a long output hold included.",
                 reg_writes);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
